// ----- rtl/sha256_stream_hasher_macros.svh -----
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication outside reset
`define SHA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/sha_pkg.sv -----
// shared types, constants and functions for the sha-256 stream hasher
package sha_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	// controller to datapath
	typedef struct packed {
		logic      push;       // shift one byte into the block buffer
		byte_src_t src;
		logic      count_len;  // add 8 to the bit length
		logic      start;      // load working vars from hash state
		logic      round;      // run one compression round
		logic      add;        // fold working vars into hash state
		logic      emit_load;  // latch next digest word into output register
		logic      clear;      // restore reset state after digest
	} sha_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [5:0] byte_count;
		logic [5:0] round_count;
		logic [2:0] emit_index;
	} sha_status_t;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- rtl/sha_ctrl.sv -----
// controller state machine: byte loading, padding, rounds and digest output
module sha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                out_free,
	input  sha_pkg::sha_status_t status,
	output sha_pkg::sha_cmd_t   cmd
);
	import sha_pkg::*;

	state_t state_q, state_d;
	logic   final_q, final_d;  // set once the last message byte is in
	logic   padded_q;
	logic   pad_done_q;

	wire in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		final_d = final_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire) begin
					if (status.byte_count == 6'd63)
						state_d = ST_ROUND;
					else if (in_last)
						state_d = ST_PAD;
					final_d = in_last;
				end
			end
			ST_PAD: begin
				// 0x80 then zeros until the length field position
				if (status.byte_count == 6'd63)
					state_d = ST_ROUND;
				else if (status.byte_count == LEN_POS - 6'd1)
					state_d = ST_LEN;
			end
			ST_LEN: begin
				if (status.byte_count == 6'd63) begin
					state_d = ST_ROUND;
					final_d = 1'b0;
				end
			end
			ST_ROUND: begin
				if (status.round_count == 6'd63)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (final_q)
					state_d = ST_PAD;
				else if (padded_q)
					state_d = ST_EMIT;
				else
					state_d = ST_LOAD;
			end
			ST_EMIT: begin
				if (out_free && status.emit_index == 3'd7)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// padded_q marks that the block just compressed carried the length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			padded_q <= 1'b0;
		else if (state_q == ST_LEN && status.byte_count == 6'd63)
			padded_q <= 1'b1;
		else if (state_q == ST_ADD)
			padded_q <= 1'b0;
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.src = SRC_DATA;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.push = in_fire;
				cmd.count_len = in_fire;
				cmd.start = in_fire && status.byte_count == 6'd63;
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				// 0x80 only right after the last byte, i.e. when final block not yet padded
				cmd.src = pad_done_q ? SRC_ZERO : SRC_PAD80;
				cmd.start = status.byte_count == 6'd63;
			end
			ST_LEN: begin
				cmd.push = 1'b1;
				cmd.src = SRC_LEN;
				cmd.start = status.byte_count == 6'd63;
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD:   cmd.add = 1'b1;
			ST_EMIT: begin
				cmd.emit_load = out_free;
				cmd.clear = out_free && status.emit_index == 3'd7;
			end
			default: ;
		endcase
	end

	// the 0x80 marker goes out once per message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pad_done_q <= 1'b0;
		else if (state_q == ST_PAD)
			pad_done_q <= 1'b1;
		else if (state_q == ST_EMIT)
			pad_done_q <= 1'b0;
	end

	`include "sha256_stream_hasher_macros.svh"
	`SHA_ASSERT_IMP(a_ready_only_load, in_ready, state_q == ST_LOAD, "ready outside load")
	`SHA_ASSERT_IMP(a_one_op, 1'b1, !(cmd.push && cmd.round), "push during round")
	`SHA_ASSERT_NXT(a_round_after_start, cmd.start, state_q == ST_ROUND, "start without round")

endmodule

// ----- rtl/sha_datapath.sv -----
// datapath: block buffer, schedule expansion, round unit, hash state, output register
module sha_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  sha_pkg::sha_cmd_t    cmd,
	output sha_pkg::sha_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_free,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 digest_last
);
	import sha_pkg::*;

	word_t       w_q [16];
	word_t       h_q [8];
	word_t       v_q [8];
	logic [5:0]  bcnt_q;
	logic [5:0]  rcnt_q;
	logic [63:0] len_q;
	logic [2:0]  eidx_q;
	logic        ovalid_q;
	word_t       oword_q;
	logic [2:0]  oidx_q;

	logic [7:0] byte_in;
	logic [2:0] len_sel;
	assign len_sel = 3'd7 - bcnt_q[2:0];

	always_comb begin
		unique case (cmd.src)
			SRC_DATA:  byte_in = data_byte;
			SRC_PAD80: byte_in = PAD_BYTE;
			SRC_ZERO:  byte_in = 8'h00;
			SRC_LEN:   byte_in = len_q[{len_sel, 3'b000} +: 8];
			default:   byte_in = 8'h00;
		endcase
	end

	// schedule and round
	logic [3:0] slot;
	word_t w15, w2, s0, s1, w_new, w_cur, t1, t2;
	assign slot = rcnt_q[3:0];
	assign w15 = w_q[slot + 4'd1];
	assign w2 = w_q[slot + 4'd14];
	assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
	assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
	assign w_new = w_q[slot] + s0 + w_q[slot + 4'd9] + s1;
	assign w_cur = (rcnt_q >= 6'd16) ? w_new : w_q[slot];
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rcnt_q] + w_cur;
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.push)
			w_q[bcnt_q[5:2]] <= {w_q[bcnt_q[5:2]][23:0], byte_in};
		else if (cmd.round)
			w_q[slot] <= w_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= H_INIT;
			v_q <= '{default: '0};
			bcnt_q <= '0;
			rcnt_q <= '0;
			len_q <= '0;
			eidx_q <= '0;
		end else begin
			if (cmd.push)
				bcnt_q <= bcnt_q + 6'd1;
			if (cmd.count_len)
				len_q <= len_q + 64'd8;
			if (cmd.start)
				v_q <= h_q;
			if (cmd.round) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				rcnt_q <= rcnt_q + 6'd1;
			end
			if (cmd.add)
				for (int j = 0; j < 8; j++)
					h_q[j] <= h_q[j] + v_q[j];
			if (cmd.emit_load)
				eidx_q <= eidx_q + 3'd1;
			if (cmd.clear) begin
				h_q <= H_INIT;
				v_q <= '{default: '0};
				bcnt_q <= '0;
				len_q <= '0;
				eidx_q <= '0;
			end
		end
	end

	// output register, frees when empty or taken
	assign out_free = !ovalid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.emit_load)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			oword_q <= h_q[eidx_q];
			oidx_q <= eidx_q;
		end
	end

	assign status.byte_count = bcnt_q;
	assign status.round_count = rcnt_q;
	assign status.emit_index = eidx_q;
	assign out_valid = ovalid_q;
	assign digest_word = oword_q;
	assign word_index = oidx_q;
	assign digest_last = oidx_q == 3'd7;

	`include "sha256_stream_hasher_macros.svh"
	`SHA_ASSERT_IMP(a_no_push_round, cmd.push, !cmd.round, "push and round together")
	`SHA_ASSERT_NXT(a_round_wrap, cmd.round && rcnt_q == 6'd63, rcnt_q == 6'd0, "round wrap")
	`SHA_ASSERT_IMP(a_emit_free, cmd.emit_load, out_free, "emit into full register")

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// top level of the sha-256 stream hasher
// Bytes stream in at one per cycle until a 64-byte block is full; the block is then
// compressed by one shared round unit, one round per cycle, and folded into the hash
// state, with input held off throughout. On the last byte the rest of the current block is
// filled at one byte per cycle with 0x80, zeros and the 64-bit length, spilling into one
// more block when fewer than nine bytes remain, each block compressed the same way; the
// eight digest words, word 0 first, are then loaded into an output register at one per
// cycle while the sink keeps up, and no new byte is taken until the eighth word is loaded.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast    // digest_last
);
	import sha_pkg::*;

	sha_cmd_t    cmd;
	sha_status_t status;
	logic        out_free;
	logic [31:0] dword;
	logic [2:0]  widx;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_last(s_tlast), .in_ready(s_tready),
		.out_free(out_free), .status(status), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(s_tdata), .cmd(cmd), .status(status),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_free(out_free),
		.digest_word(dword), .word_index(widx), .digest_last(m_tlast)
	);

	assign m_tdata = {5'd0, widx, dword};

endmodule
